>>> hdl/npq_pkg.sv
// Shared widths, pipeline depths and types for the nearest-point-on-outline block.
// No dependencies; every other file in hdl/ imports this package.
package npq_pkg;

   localparam int CoordW    = 32;               // Q16.16 coordinate
   localparam int DiffW     = CoordW + 1;       // difference of two coordinates
   localparam int SqW       = 2 * CoordW;       // square of one difference
   localparam int EeW       = SqW + 1;          // sum of two squares
   localparam int ProdW     = 2 * DiffW;        // signed product of two differences
   localparam int DotW      = ProdW + 1;        // dot product
   localparam int LoW       = DiffW;            // low slice of the dot in the split multiply
   localparam int NumW      = EeW + CoordW;     // dividend of the projection
   localparam int DivStages = CoordW;           // one quotient bit per stage

   localparam int NumEdges  = 4;
   localparam int NumCand   = NumEdges + 1;

   localparam int EdgeLat   = 5;
   localparam int DivLat    = DivStages + 1;
   localparam int PickLat   = 8;
   localparam int GeoDepth  = 1 + EdgeLat + DivLat;
   localparam int PipeDepth = GeoDepth + PickLat;

   localparam int ThrW      = 31;
   localparam int Thr2W     = 2 * ThrW;
   localparam int CsrAddrW  = 3;
   localparam int CsrDataW  = 32;

   localparam logic [0:0] REG_NEAR_THRESHOLD = 1'b0;

   typedef enum logic [1:0] {
      CLS_START,
      CLS_END,
      CLS_PROJ
   } cls_type;

   typedef struct packed {
      logic [NumW-1:0] num_x;
      logic [NumW-1:0] num_y;
      logic [EeW-1:0]  ee;
      logic            neg_x;
      logic            neg_y;
   } edge_res_type;

   typedef struct packed {
      logic [CoordW-1:0]                qx;
      logic [CoordW-1:0]                qy;
      logic [CoordW-1:0]                mx;
      logic [CoordW-1:0]                my;
      logic [NumEdges-1:0][CoordW-1:0]  cx;
      logic [NumEdges-1:0][CoordW-1:0]  cy;
   } geo_type;

endpackage

>>> hdl/nearest_point_on_quad_outline_top.sv
// Throughput: one item per clock; the pipeline freezes only while the output
// skid register holds an item, and the projection divider sets the depth.
// Reset (synchronous): clears all stage valid bits, the output and skid
// valid bits and the near threshold; the block accepts items right after.
module nearest_point_on_quad_outline_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [npq_pkg::CoordW-1:0]   req_query_x,
   input  logic signed [npq_pkg::CoordW-1:0]   req_query_y,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner0_x,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner0_y,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner1_x,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner1_y,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner2_x,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner2_y,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner3_x,
   input  logic signed [npq_pkg::CoordW-1:0]   req_corner3_y,
   input  logic signed [npq_pkg::CoordW-1:0]   req_centre_x,
   input  logic signed [npq_pkg::CoordW-1:0]   req_centre_y,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [npq_pkg::CoordW-1:0]   rsp_nearest_x,
   output logic signed [npq_pkg::CoordW-1:0]   rsp_nearest_y,
   output logic                                rsp_is_near,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [npq_pkg::CsrAddrW-1:0]        csr_paddr,
   input  logic [npq_pkg::CsrDataW-1:0]        csr_pwdata,
   output logic [npq_pkg::CsrDataW-1:0]        csr_prdata,
   output logic                                csr_pready
);
   import npq_pkg::*;

   logic                          adv;
   logic [PipeDepth-1:0]          v_ff;
   geo_type                       geo_in;
   geo_type                       geo_ff [GeoDepth];
   cls_type                       cls_ff [DivLat][NumEdges];
   cls_type                       edge_cls [NumEdges];
   edge_res_type                  edge_res [NumEdges];
   logic [NumEdges-1:0][CoordW-1:0] off_x, off_y;

   logic [ThrW-1:0]               thr_ff;
   logic [Thr2W-1:0]              thr2_in, thr2_ff;
   logic                          csr_wr;
   logic [0:0]                    csr_index;

   logic [CoordW-1:0]             pick_x, pick_y;
   logic                          pick_near;
   logic                          arrive, rsp_take;

   logic                          rsp_valid_ff, skid_valid_ff;
   logic [CoordW-1:0]             rsp_x_ff, rsp_y_ff, skid_x_ff, skid_y_ff;
   logic                          rsp_near_ff, skid_near_ff;

   // Advance the whole pipeline unless the skid stage is occupied
   assign adv       = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_comb begin
      geo_in.qx    = req_query_x;
      geo_in.qy    = req_query_y;
      geo_in.mx    = req_centre_x;
      geo_in.my    = req_centre_y;
      geo_in.cx[0] = req_corner0_x;
      geo_in.cy[0] = req_corner0_y;
      geo_in.cx[1] = req_corner1_x;
      geo_in.cy[1] = req_corner1_y;
      geo_in.cx[2] = req_corner2_x;
      geo_in.cy[2] = req_corner2_y;
      geo_in.cx[3] = req_corner3_x;
      geo_in.cy[3] = req_corner3_y;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_ff[0] <= geo_in;
         for (int k = 1; k < GeoDepth; k++) begin
            geo_ff[k] <= geo_ff[k-1];
         end
         cls_ff[0] <= edge_cls;
         for (int k = 1; k < DivLat; k++) begin
            cls_ff[k] <= cls_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[PipeDepth-2:0], req_valid};
      end
   end

   for (genvar i = 0; i < NumEdges; i++) begin : g_edge
      localparam int J = (i + 1) % NumEdges;
      npq_edge u_edge (
         .clock (clock),
         .adv   (adv),
         .ax    ($signed(geo_ff[0].cx[i])),
         .ay    ($signed(geo_ff[0].cy[i])),
         .bx    ($signed(geo_ff[0].cx[J])),
         .by    ($signed(geo_ff[0].cy[J])),
         .qx    ($signed(geo_ff[0].qx)),
         .qy    ($signed(geo_ff[0].qy)),
         .res   (edge_res[i]),
         .cls   (edge_cls[i])
      );

      npq_div u_div_x (
         .clock (clock),
         .adv   (adv),
         .num   (edge_res[i].num_x),
         .den   (edge_res[i].ee),
         .neg   (edge_res[i].neg_x),
         .off   (off_x[i])
      );

      npq_div u_div_y (
         .clock (clock),
         .adv   (adv),
         .num   (edge_res[i].num_y),
         .den   (edge_res[i].ee),
         .neg   (edge_res[i].neg_y),
         .off   (off_y[i])
      );
   end

   npq_pick u_pick (
      .clock     (clock),
      .adv       (adv),
      .geo       (geo_ff[GeoDepth-1]),
      .cls       (cls_ff[DivLat-1]),
      .off_x     (off_x),
      .off_y     (off_y),
      .thr2      (thr2_ff),
      .nearest_x (pick_x),
      .nearest_y (pick_y),
      .is_near   (pick_near)
   );

   // Configuration port
   assign csr_index  = csr_paddr[2:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == REG_NEAR_THRESHOLD) ? CsrDataW'(thr_ff) : '0;
   assign thr2_in    = thr_ff * thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr && csr_index == REG_NEAR_THRESHOLD) begin
         thr_ff <= csr_pwdata[ThrW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      thr2_ff <= thr2_in;
   end

   // Output register with one skid entry behind it
   assign arrive   = adv & v_ff[PipeDepth-1];
   assign rsp_take = rsp_valid_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_ff  <= skid_valid_ff | arrive;
         skid_valid_ff <= 1'b0;
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_x_ff    <= skid_x_ff;
            rsp_y_ff    <= skid_y_ff;
            rsp_near_ff <= skid_near_ff;
         end else begin
            rsp_x_ff    <= pick_x;
            rsp_y_ff    <= pick_y;
            rsp_near_ff <= pick_near;
         end
      end else if (arrive) begin
         skid_x_ff    <= pick_x;
         skid_y_ff    <= pick_y;
         skid_near_ff <= pick_near;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_nearest_x = $signed(rsp_x_ff);
   assign rsp_nearest_y = $signed(rsp_y_ff);
   assign rsp_is_near   = rsp_near_ff;

endmodule

>>> hdl/npq_edge.sv
// Per-edge front end: edge vector, squared length, dot product, clamp class
// and the projection dividends. Five register stages. Depends on npq_pkg.
module npq_edge (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [npq_pkg::CoordW-1:0] ax,
   input  logic signed [npq_pkg::CoordW-1:0] ay,
   input  logic signed [npq_pkg::CoordW-1:0] bx,
   input  logic signed [npq_pkg::CoordW-1:0] by,
   input  logic signed [npq_pkg::CoordW-1:0] qx,
   input  logic signed [npq_pkg::CoordW-1:0] qy,
   output npq_pkg::edge_res_type             res,
   output npq_pkg::cls_type                  cls
);
   import npq_pkg::*;

   logic signed [DiffW-1:0]   ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [DiffW-1:0]   ex_in, ey_in, wx_in, wy_in;

   logic signed [ProdW-1:0]   sxx, syy, pwx_in, pwy_in;
   logic signed [DiffW-1:0]   ex_neg, ey_neg;
   logic [SqW-1:0]            pxx_ff, pyy_ff;
   logic signed [ProdW-1:0]   pwx_ff, pwy_ff;
   logic [CoordW-1:0]         mx2_ff, my2_ff;
   logic                      nx2_ff, ny2_ff;

   logic [EeW-1:0]            ee3_ff, ee3_in;
   logic signed [DotW-1:0]    dot3_ff, dot3_in;
   logic [CoordW-1:0]         mx3_ff, my3_ff;
   logic                      nx3_ff, ny3_ff;

   logic [LoW+CoordW-1:0]     plo_x_in, plo_y_in, plo_x_ff, plo_y_ff;
   logic [SqW-1:0]            phi_x_in, phi_y_in, phi_x_ff, phi_y_ff;
   logic [EeW-1:0]            ee4_ff;
   logic                      nx4_ff, ny4_ff;
   cls_type                   cls4_in, cls4_ff;

   edge_res_type              res_ff, res_in;
   cls_type                   cls5_ff;

   assign ex_in = $signed({bx[CoordW-1], bx}) - $signed({ax[CoordW-1], ax});
   assign ey_in = $signed({by[CoordW-1], by}) - $signed({ay[CoordW-1], ay});
   assign wx_in = $signed({qx[CoordW-1], qx}) - $signed({ax[CoordW-1], ax});
   assign wy_in = $signed({qy[CoordW-1], qy}) - $signed({ay[CoordW-1], ay});

   assign sxx    = ex_ff * ex_ff;
   assign syy    = ey_ff * ey_ff;
   assign pwx_in = wx_ff * ex_ff;
   assign pwy_in = wy_ff * ey_ff;
   assign ex_neg = -ex_ff;
   assign ey_neg = -ey_ff;

   assign ee3_in  = {1'b0, pxx_ff} + {1'b0, pyy_ff};
   assign dot3_in = $signed({pwx_ff[ProdW-1], pwx_ff}) + $signed({pwy_ff[ProdW-1], pwy_ff});

   // Split the dividend multiply into two partial products
   assign plo_x_in = dot3_ff[LoW-1:0] * mx3_ff;
   assign plo_y_in = dot3_ff[LoW-1:0] * my3_ff;
   assign phi_x_in = dot3_ff[EeW-1:LoW] * mx3_ff;
   assign phi_y_in = dot3_ff[EeW-1:LoW] * my3_ff;

   always_comb begin
      if (ee3_ff == '0 || dot3_ff[DotW-1]) begin
         cls4_in = CLS_START;
      end else if ({2'b0, ee3_ff} < $unsigned(dot3_ff)) begin
         cls4_in = CLS_END;
      end else begin
         cls4_in = CLS_PROJ;
      end
   end

   always_comb begin
      res_in.num_x = NumW'(plo_x_ff) + {phi_x_ff, {LoW{1'b0}}};
      res_in.num_y = NumW'(plo_y_ff) + {phi_y_ff, {LoW{1'b0}}};
      res_in.ee    = ee4_ff;
      res_in.neg_x = nx4_ff;
      res_in.neg_y = ny4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;

         pxx_ff   <= sxx[SqW-1:0];
         pyy_ff   <= syy[SqW-1:0];
         pwx_ff   <= pwx_in;
         pwy_ff   <= pwy_in;
         mx2_ff   <= ex_ff[DiffW-1] ? ex_neg[CoordW-1:0] : ex_ff[CoordW-1:0];
         my2_ff   <= ey_ff[DiffW-1] ? ey_neg[CoordW-1:0] : ey_ff[CoordW-1:0];
         nx2_ff   <= ex_ff[DiffW-1];
         ny2_ff   <= ey_ff[DiffW-1];

         ee3_ff   <= ee3_in;
         dot3_ff  <= dot3_in;
         mx3_ff   <= mx2_ff;
         my3_ff   <= my2_ff;
         nx3_ff   <= nx2_ff;
         ny3_ff   <= ny2_ff;

         plo_x_ff <= plo_x_in;
         plo_y_ff <= plo_y_in;
         phi_x_ff <= phi_x_in;
         phi_y_ff <= phi_y_in;
         ee4_ff   <= ee3_ff;
         nx4_ff   <= nx3_ff;
         ny4_ff   <= ny3_ff;
         cls4_ff  <= cls4_in;

         res_ff   <= res_in;
         cls5_ff  <= cls4_ff;
      end
   end

   assign res = res_ff;
   assign cls = cls5_ff;

endmodule

>>> hdl/npq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with round half
// away from zero and sign applied in the last stage. Depends on npq_pkg.
module npq_div (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [npq_pkg::NumW-1:0]     num,
   input  logic [npq_pkg::EeW-1:0]      den,
   input  logic                         neg,
   output logic [npq_pkg::CoordW-1:0]   off
);
   import npq_pkg::*;

   logic [NumW-1:0]   rem_ff [DivStages];
   logic [NumW-1:0]   rem_in [DivStages];
   logic [CoordW-1:0] q_ff   [DivStages];
   logic [CoordW-1:0] q_in   [DivStages];
   logic [EeW-1:0]    den_ff [DivStages];
   logic [EeW-1:0]    den_in [DivStages];
   logic              neg_ff [DivStages];
   logic              neg_in [DivStages];

   logic [EeW-1:0]    rem_last;
   logic              round_up;
   logic [CoordW-1:0] q_rnd;
   logic [CoordW-1:0] off_ff;

   for (genvar k = 0; k < DivStages; k++) begin : g_step
      localparam int Bit = DivStages - 1 - k;
      logic [NumW-1:0]   src;
      logic [NumW-1:0]   trial;
      logic [CoordW-1:0] qsrc;
      logic              fits;

      if (k == 0) begin : g_first
         assign src        = num;
         assign qsrc       = '0;
         assign den_in[k]  = den;
         assign neg_in[k]  = neg;
      end else begin : g_next
         assign src        = rem_ff[k-1];
         assign qsrc       = q_ff[k-1];
         assign den_in[k]  = den_ff[k-1];
         assign neg_in[k]  = neg_ff[k-1];
      end

      assign trial     = NumW'(den_in[k]) << Bit;
      assign fits      = (src >= trial);
      assign rem_in[k] = fits ? src - trial : src;
      assign q_in[k]   = qsrc | (CoordW'(fits) << Bit);
   end

   assign rem_last = rem_ff[DivStages-1][EeW-1:0];
   assign round_up = ({rem_last, 1'b0} >= {1'b0, den_ff[DivStages-1]});
   assign q_rnd    = q_ff[DivStages-1] + CoordW'(round_up);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DivStages; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_in[k];
            neg_ff[k] <= neg_in[k];
         end
         off_ff <= neg_ff[DivStages-1] ? -q_rnd : q_rnd;
      end
   end

   assign off = off_ff;

endmodule

>>> hdl/npq_pick.sv
// Candidate build, squared distances, first-strict-minimum tree and the
// threshold compare. Eight register stages. Depends on npq_pkg.
module npq_pick (
   input  logic                                            clock,
   input  logic                                            adv,
   input  npq_pkg::geo_type                                geo,
   input  npq_pkg::cls_type                                cls [npq_pkg::NumEdges],
   input  logic [npq_pkg::NumEdges-1:0][npq_pkg::CoordW-1:0] off_x,
   input  logic [npq_pkg::NumEdges-1:0][npq_pkg::CoordW-1:0] off_y,
   input  logic [npq_pkg::Thr2W-1:0]                       thr2,
   output logic [npq_pkg::CoordW-1:0]                      nearest_x,
   output logic [npq_pkg::CoordW-1:0]                      nearest_y,
   output logic                                            is_near
);
   import npq_pkg::*;

   logic [CoordW-1:0]       cx_in [NumCand];
   logic [CoordW-1:0]       cy_in [NumCand];
   logic [CoordW-1:0]       cx1_ff [NumCand], cy1_ff [NumCand];
   logic [CoordW-1:0]       qx1_ff, qy1_ff;

   logic signed [DiffW-1:0] dx_ff [NumCand], dy_ff [NumCand];
   logic [CoordW-1:0]       cx2_ff [NumCand], cy2_ff [NumCand];

   logic signed [ProdW-1:0] prx [NumCand], pry [NumCand];
   logic [SqW-1:0]          sqx_ff [NumCand], sqy_ff [NumCand];
   logic [CoordW-1:0]       cx3_ff [NumCand], cy3_ff [NumCand];

   logic [EeW-1:0]          d_ff [NumCand];
   logic [CoordW-1:0]       cx4_ff [NumCand], cy4_ff [NumCand];

   logic [EeW-1:0]          d01_ff, d23_ff, d45_ff;
   logic [CoordW-1:0]       x01_ff, y01_ff, x23_ff, y23_ff, x45_ff, y45_ff;

   logic [EeW-1:0]          d03_ff, d46_ff;
   logic [CoordW-1:0]       x03_ff, y03_ff, x46_ff, y46_ff;

   logic [EeW-1:0]          db_ff;
   logic [CoordW-1:0]       xb_ff, yb_ff;

   logic [CoordW-1:0]       xo_ff, yo_ff;
   logic                    near_ff;

   for (genvar i = 0; i < NumEdges; i++) begin : g_cand
      localparam int J = (i + 1) % NumEdges;
      always_comb begin
         case (cls[i])
            CLS_START: begin
               cx_in[i] = geo.cx[i];
               cy_in[i] = geo.cy[i];
            end
            CLS_END: begin
               cx_in[i] = geo.cx[J];
               cy_in[i] = geo.cy[J];
            end
            default: begin
               cx_in[i] = geo.cx[i] + off_x[i];
               cy_in[i] = geo.cy[i] + off_y[i];
            end
         endcase
      end
   end
   assign cx_in[NumEdges] = geo.mx;
   assign cy_in[NumEdges] = geo.my;

   always_comb begin
      for (int k = 0; k < NumCand; k++) begin
         prx[k] = dx_ff[k] * dx_ff[k];
         pry[k] = dy_ff[k] * dy_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx1_ff <= geo.qx;
         qy1_ff <= geo.qy;
         for (int k = 0; k < NumCand; k++) begin
            cx1_ff[k] <= cx_in[k];
            cy1_ff[k] <= cy_in[k];

            dx_ff[k]  <= $signed({qx1_ff[CoordW-1], qx1_ff})
                         - $signed({cx1_ff[k][CoordW-1], cx1_ff[k]});
            dy_ff[k]  <= $signed({qy1_ff[CoordW-1], qy1_ff})
                         - $signed({cy1_ff[k][CoordW-1], cy1_ff[k]});
            cx2_ff[k] <= cx1_ff[k];
            cy2_ff[k] <= cy1_ff[k];

            sqx_ff[k] <= prx[k][SqW-1:0];
            sqy_ff[k] <= pry[k][SqW-1:0];
            cx3_ff[k] <= cx2_ff[k];
            cy3_ff[k] <= cy2_ff[k];

            d_ff[k]   <= {1'b0, sqx_ff[k]} + {1'b0, sqy_ff[k]};
            cx4_ff[k] <= cx3_ff[k];
            cy4_ff[k] <= cy3_ff[k];
         end

         // Later candidate wins only when strictly nearer
         if (d_ff[1] < d_ff[0]) begin
            d01_ff <= d_ff[1]; x01_ff <= cx4_ff[1]; y01_ff <= cy4_ff[1];
         end else begin
            d01_ff <= d_ff[0]; x01_ff <= cx4_ff[0]; y01_ff <= cy4_ff[0];
         end
         if (d_ff[3] < d_ff[2]) begin
            d23_ff <= d_ff[3]; x23_ff <= cx4_ff[3]; y23_ff <= cy4_ff[3];
         end else begin
            d23_ff <= d_ff[2]; x23_ff <= cx4_ff[2]; y23_ff <= cy4_ff[2];
         end
         d45_ff <= d_ff[NumEdges];
         x45_ff <= cx4_ff[NumEdges];
         y45_ff <= cy4_ff[NumEdges];

         if (d23_ff < d01_ff) begin
            d03_ff <= d23_ff; x03_ff <= x23_ff; y03_ff <= y23_ff;
         end else begin
            d03_ff <= d01_ff; x03_ff <= x01_ff; y03_ff <= y01_ff;
         end
         d46_ff <= d45_ff;
         x46_ff <= x45_ff;
         y46_ff <= y45_ff;

         if (d46_ff < d03_ff) begin
            db_ff <= d46_ff; xb_ff <= x46_ff; yb_ff <= y46_ff;
         end else begin
            db_ff <= d03_ff; xb_ff <= x03_ff; yb_ff <= y03_ff;
         end

         xo_ff   <= xb_ff;
         yo_ff   <= yb_ff;
         near_ff <= (db_ff < EeW'(thr2));
      end
   end

   assign nearest_x = xo_ff;
   assign nearest_y = yo_ff;
   assign is_near   = near_ff;

endmodule
